### rtl/core/assert_macros.svh
// Assertion macros for the RTL of the pattern scanner, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PBM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define PBM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pbm_pkg.sv
// Package of types and constants for the byte pattern match scanner.
package pbm_pkg;

   // Default sizing of the top level
   localparam int PBM_MAX_PATTERN   = 32;
   localparam int PBM_POSITION_BITS = 32;

   // Fixed widths of the register file and of the pattern store
   localparam int PBM_LEN_W       = 6;
   localparam int PBM_PAT_BYTES   = 32;
   localparam int PBM_IDX_W       = 5;
   localparam int PBM_CSR_ADDR_W  = 6;
   localparam int PBM_CSR_DATA_W  = 64;
   localparam int PBM_OFFSET_W    = 32;

   // Register indexes, taken from the address in 8-byte steps
   typedef enum logic [2:0] {
      REG_LENGTH = 3'd0,
      REG_PAT0   = 3'd1,
      REG_PAT1   = 3'd2,
      REG_PAT2   = 3'd3,
      REG_PAT3   = 3'd4
   } pbm_reg_type;

   // Pattern settings handed from the register file to the cell row
   typedef struct packed {
      logic [PBM_LEN_W-1:0]                eff_len;
      logic [PBM_PAT_BYTES-1:0][7:0]       pat;
   } pbm_cfg_type;

endpackage

### rtl/core/byte_pattern_match_scanner.sv
// Top level of the byte pattern match scanner: cell row, position count, result stage.
//
// Usage:
//   The req stream carries one source byte per transfer; tuser flags the first
//   byte of a new buffer, which restarts the offset count and empties the window.
//   For each byte that completes a match with the programmed pattern, one rsp
//   transfer carries the buffer offset where the match begins; other bytes give
//   no transfer. Overlapping matches are all reported.
//   The pattern and its length are written over the csr port while the stream
//   is idle; a length above the window depth is used as the depth, zero never
//   matches.
//   A byte enters the cell row and sets the pending flag; its result is
//   registered once the result slot is free. Throughput: one byte per cycle
//   while rsp keeps up; the row shifts once per transfer beside the prior compare.
//   When the rsp side stalls with a result waiting, one more byte is taken and
//   then req_tready drops until the result leaves.
//   Reset (synchronous) empties the window, clears the offset count, drops any
//   waiting result and loads length 1 with an all-zero pattern.
//   The offset count saturates at its top value.
module byte_pattern_match_scanner import pbm_pkg::*; #(
   parameter int MAX_PATTERN   = PBM_MAX_PATTERN,
   parameter int POSITION_BITS = PBM_POSITION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   // Source byte stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] source_byte
   input  logic [0:0]                req_tuser,   // [0] start_of_buffer
   // Match stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [PBM_OFFSET_W-1:0]   rsp_tdata,   // [31:0] match_offset
   // Configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [PBM_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [PBM_CSR_DATA_W-1:0] csr_pwdata,
   output logic [PBM_CSR_DATA_W-1:0] csr_prdata,
   output logic                      csr_pready
);

   `include "assert_macros.svh"

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   pbm_cfg_type                     cfg;
   logic [MAX_PATTERN-1:0][7:0]     cell_data;
   logic [MAX_PATTERN-1:0]          cell_valid;
   logic [MAX_PATTERN-1:0]          cell_ok;

   logic                            accept;
   logic                            out_free;
   logic                            advance;
   logic                            hit;
   logic [POSITION_BITS-1:0]        here_now;
   logic [POSITION_BITS-1:0]        pos_ff, pos_in;
   logic [POSITION_BITS-1:0]        here_ff, here_in;
   logic                            pend_ff, pend_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [PBM_OFFSET_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [PBM_LEN_W-1:0]            len_m1;
   logic [POSITION_BITS-1:0]        start_pos;
   logic [POSITION_BITS+PBM_OFFSET_W-1:0] start_ext;

   pbm_csr #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake: a waiting compare needs a free result slot before the row moves
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = pend_ff && out_free;
   assign req_tready = !pend_ff || out_free;

   // Build the row of window cells; cell 0 takes the incoming byte
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [7:0] prev_data;
      logic       prev_valid;
      if (j == 0) begin : g_head
         assign prev_data  = req_tdata;
         assign prev_valid = 1'b1;
      end else begin : g_link
         assign prev_data  = cell_data[j-1];
         assign prev_valid = cell_valid[j-1];
      end
      pbm_cell #(
         .IDX (j)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .start      (req_tuser[0]),
         .prev_data  (prev_data),
         .prev_valid (prev_valid),
         .cfg        (cfg),
         .data_out   (cell_data[j]),
         .valid_out  (cell_valid[j]),
         .ok         (cell_ok[j])
      );
   end

   // Offset of the incoming byte and the saturating count
   always_comb begin
      here_now = req_tuser[0] ? '0 : pos_ff;
      pos_in   = pos_ff;
      here_in  = here_ff;
      if (accept) begin
         here_in = here_now;
         pos_in  = (here_now < POS_MAX) ? here_now + POSITION_BITS'(1) : here_now;
      end
   end

   // Match over the row and the start offset of the match
   assign hit       = (cfg.eff_len != '0) && (&cell_ok);
   assign len_m1    = cfg.eff_len - PBM_LEN_W'(1);
   assign start_pos = here_ff - POSITION_BITS'(len_m1);
   assign start_ext = {{PBM_OFFSET_W{1'b0}}, start_pos};

   // Hold the compare pending until the result slot takes it
   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         pend_in = 1'b0;
      end
      if (accept) begin
         pend_in = 1'b1;
      end
      if (advance) begin
         rsp_valid_in = hit;
         rsp_data_in  = start_ext[PBM_OFFSET_W-1:0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      here_ff     <= here_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the result stage and the cell row
   `PBM_ASSERT_NEXT(a_rsp_from_pending, clock, reset, !rsp_valid_ff && !pend_ff, !rsp_valid_ff, "result appeared without a pending compare")
   `PBM_ASSERT(a_no_take_when_blocked, clock, reset, !(pend_ff && !out_free && req_tready), "byte taken while the result slot is blocked")
   `PBM_ASSERT(a_hit_needs_head, clock, reset, !(hit && pend_ff && !cell_valid[0]), "match reported from an empty window")
   `PBM_ASSERT_NEXT(a_pos_monotonic, clock, reset, accept && !req_tuser[0], pos_ff >= $past(pos_ff), "offset count went backward inside a buffer")

endmodule

### rtl/core/pbm_csr.sv
// Configuration register file of the byte pattern match scanner.
module pbm_csr import pbm_pkg::*; #(
   parameter int MAX_PATTERN = PBM_MAX_PATTERN
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [PBM_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [PBM_CSR_DATA_W-1:0] csr_pwdata,
   output logic [PBM_CSR_DATA_W-1:0] csr_prdata,
   output logic                      csr_pready,
   output pbm_cfg_type               cfg
);

   localparam logic [PBM_LEN_W-1:0] MAX_LEN = PBM_LEN_W'(MAX_PATTERN);

   logic [PBM_LEN_W-1:0]      len_ff, len_in;
   logic [PBM_CSR_DATA_W-1:0] pat0_ff, pat0_in;
   logic [PBM_CSR_DATA_W-1:0] pat1_ff, pat1_in;
   logic [PBM_CSR_DATA_W-1:0] pat2_ff, pat2_in;
   logic [PBM_CSR_DATA_W-1:0] pat3_ff, pat3_in;
   logic                      wr_en;
   pbm_reg_type               reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = pbm_reg_type'(csr_paddr[PBM_CSR_ADDR_W-1:3]);

   // Decode the write; unknown indexes leave everything as is
   always_comb begin
      len_in  = len_ff;
      pat0_in = pat0_ff;
      pat1_in = pat1_ff;
      pat2_in = pat2_ff;
      pat3_in = pat3_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LENGTH: len_in  = csr_pwdata[PBM_LEN_W-1:0];
            REG_PAT0:   pat0_in = csr_pwdata;
            REG_PAT1:   pat1_in = csr_pwdata;
            REG_PAT2:   pat2_in = csr_pwdata;
            REG_PAT3:   pat3_in = csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= PBM_LEN_W'(1);
         pat0_ff <= '0;
         pat1_ff <= '0;
         pat2_ff <= '0;
         pat3_ff <= '0;
      end else begin
         len_ff  <= len_in;
         pat0_ff <= pat0_in;
         pat1_ff <= pat1_in;
         pat2_ff <= pat2_in;
         pat3_ff <= pat3_in;
      end
   end

   // Return the addressed register
   always_comb begin
      case (reg_idx)
         REG_LENGTH: csr_prdata = {{(PBM_CSR_DATA_W-PBM_LEN_W){1'b0}}, len_ff};
         REG_PAT0:   csr_prdata = pat0_ff;
         REG_PAT1:   csr_prdata = pat1_ff;
         REG_PAT2:   csr_prdata = pat2_ff;
         REG_PAT3:   csr_prdata = pat3_ff;
         default:    csr_prdata = '0;
      endcase
   end

   // Clamp the length to the window depth and pack the pattern bytes
   assign cfg.eff_len = (len_ff > MAX_LEN) ? MAX_LEN : len_ff;
   assign cfg.pat     = {pat3_ff, pat2_ff, pat1_ff, pat0_ff};

endmodule

### rtl/core/pbm_cell.sv
// One window cell: holds a source byte and checks it against its pattern byte.
module pbm_cell import pbm_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        shift_en,
   input  logic        start,
   input  logic [7:0]  prev_data,
   input  logic        prev_valid,
   input  pbm_cfg_type cfg,
   output logic [7:0]  data_out,
   output logic        valid_out,
   output logic        ok
);

   localparam logic [PBM_LEN_W-1:0] CELL_POS = PBM_LEN_W'(IDX);
   localparam bit                   FIRST    = (IDX == 0);

   logic [7:0]           data_ff, data_in;
   logic                 valid_ff, valid_in;
   logic [PBM_LEN_W-1:0] sel;
   logic                 used;
   logic                 same;

   // Take the neighbor's byte; a buffer start drops all older bytes
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (shift_en) begin
         data_in  = prev_data;
         valid_in = prev_valid && (FIRST || !start);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Cell j lines up with pattern byte len-1-j
   assign sel  = cfg.eff_len - CELL_POS - PBM_LEN_W'(1);
   assign used = cfg.eff_len > CELL_POS;
   assign same = data_ff == cfg.pat[sel[PBM_IDX_W-1:0]];
   assign ok   = !used || (valid_ff && same);

   assign data_out  = data_ff;
   assign valid_out = valid_ff;

endmodule
